@@ hw/rtl/assert_macros.svh @@
// Assertion helpers used by the checker file.
// Both macros sample on the rising edge of clk and are off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every sampled edge.
`define ASSERT_AT(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Implication checked in the same cycle.
`define ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/lavb_pkg.sv @@
package lavb_pkg;

    // Field and datapath widths
    localparam int POS_W     = 32;
    localparam int D_W       = POS_W + 1;
    localparam int MAG_W     = POS_W;
    localparam int NORM_W    = 30;
    localparam int SQ_W      = 2 * NORM_W;
    localparam int RAD_W     = SQ_W + 2;
    localparam int ROOT_W    = RAD_W / 2;
    localparam int UNIT_FRAC = 16;
    localparam int Q_W       = UNIT_FRAC + 1;
    localparam int UNIT_W    = UNIT_FRAC + 2;
    localparam int NUM_W     = ROOT_W + Q_W;

    // Root lanes: full length and horizontal length
    localparam int ROOTS  = 2;
    localparam int ROOT_L = 0;
    localparam int ROOT_H = 1;

    // Divider lanes
    localparam int LANES = 5;
    localparam int L_WX  = 0;
    localparam int L_WY  = 1;
    localparam int L_WZ  = 2;
    localparam int L_UX  = 3;
    localparam int L_UZ  = 4;

    typedef logic signed [POS_W-1:0] pos_t;
    typedef logic [NORM_W-1:0]       norm_t;
    typedef logic [RAD_W-1:0]        rad_t;
    typedef logic [ROOT_W-1:0]       root_t;
    typedef logic [Q_W-1:0]          quo_t;
    typedef logic signed [UNIT_W-1:0] unit_t;

    // Data that rides along with each transaction
    typedef struct packed {
        pos_t pos_x;
        pos_t pos_y;
        pos_t pos_z;
        logic neg_x;
        logic neg_y;
        logic neg_z;
        logic hz_nz;
        logic degen;
    } side_t;

    // Normalized magnitudes for the divider lanes
    typedef struct packed {
        norm_t n_x;
        norm_t n_y;
        norm_t n_z;
        norm_t h_x;
        norm_t h_z;
    } mags_t;

endpackage

@@ hw/rtl/lavb_prep.sv @@
module lavb_prep (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                func,
    input  lavb_pkg::pos_t      vec_x,
    input  lavb_pkg::pos_t      vec_y,
    input  lavb_pkg::pos_t      vec_z,
    input  lavb_pkg::pos_t      pos_x,
    input  lavb_pkg::pos_t      pos_y,
    input  lavb_pkg::pos_t      pos_z,
    output logic                out_valid,
    output lavb_pkg::rad_t      rad [lavb_pkg::ROOTS],
    output lavb_pkg::mags_t     mags,
    output lavb_pkg::side_t     side
);
    import lavb_pkg::*;

    localparam int STAGES = 9;
    localparam int IDX_W  = $clog2(MAG_W);
    localparam logic [IDX_W-1:0] TOP_BIT = IDX_W'(NORM_W - 1);

    // Index of the highest set bit
    function automatic logic [IDX_W-1:0] msb_idx(input logic [MAG_W-1:0] x);
        logic [IDX_W-1:0] r;
        r = '0;
        for (int i = 0; i < MAG_W; i++) begin
            if (x[i])
            begin
                r = IDX_W'(i);
            end
        end
        return r;
    endfunction

    logic [STAGES-1:0] valid_reg;

    logic             func1_reg;
    pos_t             vec1_reg [3];
    pos_t             pos1_reg [3];
    logic [MAG_W-1:0] m2_reg [3];
    side_t            s2_reg;
    logic [MAG_W-1:0] mx3_reg;
    logic [MAG_W-1:0] m3_reg [3];
    side_t            s3_reg;
    logic [IDX_W-1:0] idx4_reg;
    logic [MAG_W-1:0] m4_reg [3];
    side_t            s4_reg;
    norm_t            n5_reg [3];
    side_t            s5_reg;
    norm_t            n6_reg [3];
    logic [IDX_W-1:0] hs6_reg;
    side_t            s6_reg;
    norm_t            n7_reg [3];
    norm_t            h7_reg [2];
    logic [SQ_W-1:0]  sq7_reg [3];
    side_t            s7_reg;
    norm_t            n8_reg [3];
    norm_t            h8_reg [2];
    rad_t             suml8_reg;
    logic [SQ_W-1:0]  hsq8_reg [2];
    side_t            s8_reg;
    norm_t            n9_reg [3];
    norm_t            h9_reg [2];
    rad_t             suml9_reg;
    rad_t             sumh9_reg;
    side_t            s9_reg;

    logic [MAG_W-1:0] m2_next [3];
    side_t            s2_next;
    logic [MAG_W-1:0] mx3_next;
    side_t            s4_next;
    norm_t            n5_next [3];
    side_t            s6_next;
    logic [IDX_W-1:0] hs6_next;
    side_t            s7_next;

    // Stage 2: direction and magnitudes
    always_comb
    begin
        logic signed [D_W-1:0] d;
        logic [2:0]            neg;
        d   = '0;
        neg = '0;
        for (int i = 0; i < 3; i++) begin
            if (func1_reg)
            begin
                d = D_W'(vec1_reg[i]) - D_W'(pos1_reg[i]);
            end
            else
            begin
                d = D_W'(vec1_reg[i]);
            end
            neg[i]     = d[D_W-1];
            m2_next[i] = d[D_W-1] ? MAG_W'(-d) : MAG_W'(d);
        end
        s2_next       = '0;
        s2_next.pos_x = pos1_reg[0];
        s2_next.pos_y = pos1_reg[1];
        s2_next.pos_z = pos1_reg[2];
        s2_next.neg_x = neg[0];
        s2_next.neg_y = neg[1];
        s2_next.neg_z = neg[2];
    end

    // Stage 3: largest magnitude
    always_comb
    begin
        mx3_next = m2_reg[0];
        if (m2_reg[1] > mx3_next)
        begin
            mx3_next = m2_reg[1];
        end
        if (m2_reg[2] > mx3_next)
        begin
            mx3_next = m2_reg[2];
        end
    end

    // Stage 4: zero direction flag
    always_comb
    begin
        s4_next       = s3_reg;
        s4_next.degen = (mx3_reg == '0);
    end

    // Stage 5: common shift puts the largest magnitude at the top bit
    always_comb
    begin
        logic [MAG_W-1:0] sh;
        sh = '0;
        for (int i = 0; i < 3; i++) begin
            if (idx4_reg >= TOP_BIT)
            begin
                sh = m4_reg[i] >> (idx4_reg - TOP_BIT);
            end
            else
            begin
                sh = m4_reg[i] << (TOP_BIT - idx4_reg);
            end
            n5_next[i] = sh[NORM_W-1:0];
        end
    end

    // Stage 6: parallel-to-up check and horizontal shift amount
    always_comb
    begin
        s6_next       = s5_reg;
        s6_next.degen = s5_reg.degen || ((n5_reg[0] == '0) && (n5_reg[2] == '0));
        hs6_next      = TOP_BIT - msb_idx(MAG_W'(n5_reg[0] | n5_reg[2]));
    end

    // Stage 7 flag
    always_comb
    begin
        s7_next       = s6_reg;
        s7_next.hz_nz = (n6_reg[2] != '0);
    end

    // Valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[STAGES-2:0], in_valid};
        end
    end

    // Payload stages
    always_ff @(posedge clk)
    begin
        func1_reg   <= func;
        vec1_reg[0] <= vec_x;
        vec1_reg[1] <= vec_y;
        vec1_reg[2] <= vec_z;
        pos1_reg[0] <= pos_x;
        pos1_reg[1] <= pos_y;
        pos1_reg[2] <= pos_z;

        m2_reg  <= m2_next;
        s2_reg  <= s2_next;

        mx3_reg <= mx3_next;
        m3_reg  <= m2_reg;
        s3_reg  <= s2_reg;

        idx4_reg <= msb_idx(mx3_reg);
        m4_reg   <= m3_reg;
        s4_reg   <= s4_next;

        n5_reg <= n5_next;
        s5_reg <= s4_reg;

        n6_reg  <= n5_reg;
        hs6_reg <= hs6_next;
        s6_reg  <= s6_next;

        n7_reg    <= n6_reg;
        h7_reg[0] <= n6_reg[0] << hs6_reg;
        h7_reg[1] <= n6_reg[2] << hs6_reg;
        for (int i = 0; i < 3; i++) begin
            sq7_reg[i] <= SQ_W'(n6_reg[i]) * SQ_W'(n6_reg[i]);
        end
        s7_reg <= s7_next;

        n8_reg      <= n7_reg;
        h8_reg      <= h7_reg;
        suml8_reg   <= RAD_W'(sq7_reg[0]) + RAD_W'(sq7_reg[1]) + RAD_W'(sq7_reg[2]);
        hsq8_reg[0] <= SQ_W'(h7_reg[0]) * SQ_W'(h7_reg[0]);
        hsq8_reg[1] <= SQ_W'(h7_reg[1]) * SQ_W'(h7_reg[1]);
        s8_reg      <= s7_reg;

        n9_reg    <= n8_reg;
        h9_reg    <= h8_reg;
        suml9_reg <= suml8_reg;
        sumh9_reg <= RAD_W'(hsq8_reg[0]) + RAD_W'(hsq8_reg[1]);
        s9_reg    <= s8_reg;
    end

    assign out_valid   = valid_reg[STAGES-1];
    assign rad[ROOT_L] = suml9_reg;
    assign rad[ROOT_H] = sumh9_reg;
    assign mags.n_x    = n9_reg[0];
    assign mags.n_y    = n9_reg[1];
    assign mags.n_z    = n9_reg[2];
    assign mags.h_x    = h9_reg[0];
    assign mags.h_z    = h9_reg[1];
    assign side        = s9_reg;

endmodule

@@ hw/rtl/lavb_sqrt.sv @@
module lavb_sqrt (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  lavb_pkg::rad_t   rad [lavb_pkg::ROOTS],
    input  lavb_pkg::mags_t  mags_in,
    input  lavb_pkg::side_t  side_in,
    output logic             out_valid,
    output lavb_pkg::root_t  root [lavb_pkg::ROOTS],
    output lavb_pkg::mags_t  mags_out,
    output lavb_pkg::side_t  side_out
);
    import lavb_pkg::*;

    // One root bit per stage, remainder carried forward
    logic [ROOT_W-1:0] valid_reg;
    rad_t              rem_reg   [ROOT_W][ROOTS];
    root_t             root_reg  [ROOT_W][ROOTS];
    mags_t             mags_reg  [ROOT_W];
    side_t             side_reg  [ROOT_W];

    rad_t              rem_cur   [ROOT_W][ROOTS];
    root_t             root_cur  [ROOT_W][ROOTS];
    rad_t              rem_next  [ROOT_W][ROOTS];
    root_t             root_next [ROOT_W][ROOTS];

    // Stage inputs
    always_comb
    begin
        for (int j = 0; j < ROOTS; j++) begin
            rem_cur[0][j]  = rad[j];
            root_cur[0][j] = '0;
        end
        for (int k = 1; k < ROOT_W; k++) begin
            for (int j = 0; j < ROOTS; j++) begin
                rem_cur[k][j]  = rem_reg[k-1][j];
                root_cur[k][j] = root_reg[k-1][j];
            end
        end
    end

    // Trial subtract of (2r + 2^b) * 2^b
    always_comb
    begin
        logic [RAD_W:0] trial;
        logic           ge;
        int             b;
        trial = '0;
        ge    = 1'b0;
        b     = 0;
        for (int k = 0; k < ROOT_W; k++) begin
            for (int j = 0; j < ROOTS; j++) begin
                b     = ROOT_W - 1 - k;
                trial = ((RAD_W+1)'(root_cur[k][j]) << (b + 1))
                      | ((RAD_W+1)'(1) << (2 * b));
                ge    = ({1'b0, rem_cur[k][j]} >= trial);
                if (ge)
                begin
                    rem_next[k][j]  = RAD_W'({1'b0, rem_cur[k][j]} - trial);
                    root_next[k][j] = root_cur[k][j] | (ROOT_W'(1) << b);
                end
                else
                begin
                    rem_next[k][j]  = rem_cur[k][j];
                    root_next[k][j] = root_cur[k][j];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[ROOT_W-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        root_reg    <= root_next;
        mags_reg[0] <= mags_in;
        side_reg[0] <= side_in;
        for (int k = 1; k < ROOT_W; k++) begin
            mags_reg[k] <= mags_reg[k-1];
            side_reg[k] <= side_reg[k-1];
        end
    end

    assign out_valid = valid_reg[ROOT_W-1];
    assign root      = root_reg[ROOT_W-1];
    assign mags_out  = mags_reg[ROOT_W-1];
    assign side_out  = side_reg[ROOT_W-1];

endmodule

@@ hw/rtl/lavb_div.sv @@
module lavb_div (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  lavb_pkg::norm_t  mag [lavb_pkg::LANES],
    input  lavb_pkg::root_t  den [lavb_pkg::LANES],
    input  lavb_pkg::side_t  side_in,
    output logic             out_valid,
    output lavb_pkg::quo_t   quo [lavb_pkg::LANES],
    output lavb_pkg::side_t  side_out
);
    import lavb_pkg::*;

    typedef logic [NUM_W-1:0] num_t;

    // Restoring division, one quotient bit per stage; the rounding half
    // of the divisor is added to the numerator up front
    logic [Q_W-1:0] valid_reg;
    num_t           rem_reg  [Q_W][LANES];
    quo_t           quo_reg  [Q_W][LANES];
    root_t          den_reg  [Q_W][LANES];
    side_t          side_reg [Q_W];

    num_t           rem_cur  [Q_W][LANES];
    quo_t           quo_cur  [Q_W][LANES];
    root_t          den_cur  [Q_W][LANES];
    num_t           rem_next [Q_W][LANES];
    quo_t           quo_next [Q_W][LANES];

    // Stage inputs
    always_comb
    begin
        for (int j = 0; j < LANES; j++) begin
            rem_cur[0][j] = (NUM_W'(mag[j]) << UNIT_FRAC) + NUM_W'(den[j] >> 1);
            quo_cur[0][j] = '0;
            den_cur[0][j] = den[j];
        end
        for (int k = 1; k < Q_W; k++) begin
            for (int j = 0; j < LANES; j++) begin
                rem_cur[k][j] = rem_reg[k-1][j];
                quo_cur[k][j] = quo_reg[k-1][j];
                den_cur[k][j] = den_reg[k-1][j];
            end
        end
    end

    // Compare and subtract the shifted divisor
    always_comb
    begin
        num_t dsh;
        int   b;
        dsh = '0;
        b   = 0;
        for (int k = 0; k < Q_W; k++) begin
            for (int j = 0; j < LANES; j++) begin
                b   = Q_W - 1 - k;
                dsh = NUM_W'(den_cur[k][j]) << b;
                if (rem_cur[k][j] >= dsh)
                begin
                    rem_next[k][j] = rem_cur[k][j] - dsh;
                    quo_next[k][j] = quo_cur[k][j] | (Q_W'(1) << b);
                end
                else
                begin
                    rem_next[k][j] = rem_cur[k][j];
                    quo_next[k][j] = quo_cur[k][j];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[Q_W-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        den_reg     <= den_cur;
        side_reg[0] <= side_in;
        for (int k = 1; k < Q_W; k++) begin
            side_reg[k] <= side_reg[k-1];
        end
    end

    assign out_valid = valid_reg[Q_W-1];
    assign quo       = quo_reg[Q_W-1];
    assign side_out  = side_reg[Q_W-1];

endmodule

@@ hw/rtl/lavb_post.sv @@
module lavb_post (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  lavb_pkg::quo_t         quo [lavb_pkg::LANES],
    input  lavb_pkg::side_t        side_in,
    output logic                   done,
    output lavb_pkg::unit_t        right_x,
    output lavb_pkg::unit_t        right_z,
    output lavb_pkg::unit_t        upv_x,
    output lavb_pkg::unit_t        upv_y,
    output lavb_pkg::unit_t        upv_z,
    output lavb_pkg::unit_t        fwd_x,
    output lavb_pkg::unit_t        fwd_y,
    output lavb_pkg::unit_t        fwd_z,
    output lavb_pkg::pos_t         trans_u,
    output lavb_pkg::pos_t         trans_v,
    output lavb_pkg::pos_t         trans_w
);
    import lavb_pkg::*;

    localparam int STAGES = 6;
    localparam int PAIR_W = 2 * UNIT_W;
    localparam int PROD_W = UNIT_W + POS_W;
    localparam int DOT_W  = PROD_W + 2;

    typedef logic signed [PAIR_W-1:0] pair_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [DOT_W-1:0]  dot_t;

    localparam dot_t ONE_D  = dot_t'(1) <<< UNIT_FRAC;
    localparam dot_t POS_HI = (dot_t'(1) <<< (POS_W - 1)) - dot_t'(1);
    localparam dot_t POS_LO = -(dot_t'(1) <<< (POS_W - 1));

    // Signed unit from quotient magnitude
    function automatic unit_t to_unit(input logic neg, input quo_t q);
        unit_t s;
        s = $signed({1'b0, q});
        return neg ? -s : s;
    endfunction

    // Drop 16 fraction bits, half away from zero
    function automatic dot_t round16(input dot_t x);
        logic [DOT_W-1:0] a;
        a = x[DOT_W-1] ? DOT_W'(-x) : DOT_W'(x);
        a = (a + (DOT_W'(1) << (UNIT_FRAC - 1))) >> UNIT_FRAC;
        return x[DOT_W-1] ? -$signed(a) : $signed(a);
    endfunction

    function automatic unit_t clamp_unit(input dot_t x);
        dot_t r;
        r = x;
        if (x > ONE_D)
        begin
            r = ONE_D;
        end
        else if (x < -ONE_D)
        begin
            r = -ONE_D;
        end
        return UNIT_W'(r);
    endfunction

    function automatic pos_t sat_neg(input dot_t dot);
        dot_t r;
        r = -round16(dot);
        if (r > POS_HI)
        begin
            r = POS_HI;
        end
        else if (r < POS_LO)
        begin
            r = POS_LO;
        end
        return POS_W'(r);
    endfunction

    logic [STAGES-1:0] valid_reg;

    // Q1 units
    unit_t ux1_reg, uz1_reg, wx1_reg, wy1_reg, wz1_reg;
    side_t s1_reg;
    // Q2 products
    unit_t ux2_reg, uz2_reg, wx2_reg, wy2_reg, wz2_reg;
    pair_t wyuz2_reg, wzux2_reg, wxuz2_reg, wyux2_reg;
    prod_t tux2_reg, tuz2_reg, twx2_reg, twy2_reg, twz2_reg;
    side_t s2_reg;
    // Q3 v and dots
    unit_t ux3_reg, uz3_reg, wx3_reg, wy3_reg, wz3_reg;
    unit_t vx3_reg, vy3_reg, vz3_reg;
    dot_t  dotu3_reg, dotw3_reg;
    side_t s3_reg;
    // Q4 v products
    unit_t ux4_reg, uz4_reg, wx4_reg, wy4_reg, wz4_reg;
    unit_t vx4_reg, vy4_reg, vz4_reg;
    dot_t  dotu4_reg, dotw4_reg;
    prod_t tvx4_reg, tvy4_reg, tvz4_reg;
    side_t s4_reg;
    // Q5 v dot
    unit_t ux5_reg, uz5_reg, wx5_reg, wy5_reg, wz5_reg;
    unit_t vx5_reg, vy5_reg, vz5_reg;
    dot_t  dotu5_reg, dotv5_reg, dotw5_reg;
    side_t s5_reg;
    // Q6 result
    unit_t rx_reg, rz_reg, vx_reg, vy_reg, vz_reg, fx_reg, fy_reg, fz_reg;
    pos_t  tu_reg, tv_reg, tw_reg;

    logic ux_neg_next;
    dot_t vy_raw_next;

    assign ux_neg_next = !side_in.neg_z && side_in.hz_nz;
    assign vy_raw_next = dot_t'(wzux2_reg) - dot_t'(wxuz2_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        // Q1: apply signs
        ux1_reg <= to_unit(ux_neg_next, quo[L_UX]);
        uz1_reg <= to_unit(side_in.neg_x, quo[L_UZ]);
        wx1_reg <= to_unit(side_in.neg_x, quo[L_WX]);
        wy1_reg <= to_unit(side_in.neg_y, quo[L_WY]);
        wz1_reg <= to_unit(side_in.neg_z, quo[L_WZ]);
        s1_reg  <= side_in;

        // Q2: cross and translation products
        ux2_reg   <= ux1_reg;
        uz2_reg   <= uz1_reg;
        wx2_reg   <= wx1_reg;
        wy2_reg   <= wy1_reg;
        wz2_reg   <= wz1_reg;
        wyuz2_reg <= PAIR_W'(wy1_reg) * PAIR_W'(uz1_reg);
        wzux2_reg <= PAIR_W'(wz1_reg) * PAIR_W'(ux1_reg);
        wxuz2_reg <= PAIR_W'(wx1_reg) * PAIR_W'(uz1_reg);
        wyux2_reg <= PAIR_W'(wy1_reg) * PAIR_W'(ux1_reg);
        tux2_reg  <= PROD_W'(ux1_reg) * PROD_W'(s1_reg.pos_x);
        tuz2_reg  <= PROD_W'(uz1_reg) * PROD_W'(s1_reg.pos_z);
        twx2_reg  <= PROD_W'(wx1_reg) * PROD_W'(s1_reg.pos_x);
        twy2_reg  <= PROD_W'(wy1_reg) * PROD_W'(s1_reg.pos_y);
        twz2_reg  <= PROD_W'(wz1_reg) * PROD_W'(s1_reg.pos_z);
        s2_reg    <= s1_reg;

        // Q3: v = w x u, dots for u and w
        ux3_reg   <= ux2_reg;
        uz3_reg   <= uz2_reg;
        wx3_reg   <= wx2_reg;
        wy3_reg   <= wy2_reg;
        wz3_reg   <= wz2_reg;
        vx3_reg   <= clamp_unit(round16(dot_t'(wyuz2_reg)));
        vy3_reg   <= clamp_unit(round16(vy_raw_next));
        vz3_reg   <= clamp_unit(round16(-dot_t'(wyux2_reg)));
        dotu3_reg <= dot_t'(tux2_reg) + dot_t'(tuz2_reg);
        dotw3_reg <= dot_t'(twx2_reg) + dot_t'(twy2_reg) + dot_t'(twz2_reg);
        s3_reg    <= s2_reg;

        // Q4: v translation products
        ux4_reg   <= ux3_reg;
        uz4_reg   <= uz3_reg;
        wx4_reg   <= wx3_reg;
        wy4_reg   <= wy3_reg;
        wz4_reg   <= wz3_reg;
        vx4_reg   <= vx3_reg;
        vy4_reg   <= vy3_reg;
        vz4_reg   <= vz3_reg;
        dotu4_reg <= dotu3_reg;
        dotw4_reg <= dotw3_reg;
        tvx4_reg  <= PROD_W'(vx3_reg) * PROD_W'(s3_reg.pos_x);
        tvy4_reg  <= PROD_W'(vy3_reg) * PROD_W'(s3_reg.pos_y);
        tvz4_reg  <= PROD_W'(vz3_reg) * PROD_W'(s3_reg.pos_z);
        s4_reg    <= s3_reg;

        // Q5: v dot
        ux5_reg   <= ux4_reg;
        uz5_reg   <= uz4_reg;
        wx5_reg   <= wx4_reg;
        wy5_reg   <= wy4_reg;
        wz5_reg   <= wz4_reg;
        vx5_reg   <= vx4_reg;
        vy5_reg   <= vy4_reg;
        vz5_reg   <= vz4_reg;
        dotu5_reg <= dotu4_reg;
        dotw5_reg <= dotw4_reg;
        dotv5_reg <= dot_t'(tvx4_reg) + dot_t'(tvy4_reg) + dot_t'(tvz4_reg);
        s5_reg    <= s4_reg;

        // Q6: translation, degenerate input forces zeros
        if (s5_reg.degen)
        begin
            rx_reg <= '0;
            rz_reg <= '0;
            vx_reg <= '0;
            vy_reg <= '0;
            vz_reg <= '0;
            fx_reg <= '0;
            fy_reg <= '0;
            fz_reg <= '0;
            tu_reg <= '0;
            tv_reg <= '0;
            tw_reg <= '0;
        end
        else
        begin
            rx_reg <= ux5_reg;
            rz_reg <= uz5_reg;
            vx_reg <= vx5_reg;
            vy_reg <= vy5_reg;
            vz_reg <= vz5_reg;
            fx_reg <= wx5_reg;
            fy_reg <= wy5_reg;
            fz_reg <= wz5_reg;
            tu_reg <= sat_neg(dotu5_reg);
            tv_reg <= sat_neg(dotv5_reg);
            tw_reg <= sat_neg(dotw5_reg);
        end
    end

    assign done    = valid_reg[STAGES-1];
    assign right_x = rx_reg;
    assign right_z = rz_reg;
    assign upv_x   = vx_reg;
    assign upv_y   = vy_reg;
    assign upv_z   = vz_reg;
    assign fwd_x   = fx_reg;
    assign fwd_y   = fy_reg;
    assign fwd_z   = fz_reg;
    assign trans_u = tu_reg;
    assign trans_v = tv_reg;
    assign trans_w = tw_reg;

endmodule

@@ hw/rtl/look_at_view_basis.sv @@
// Channel   Direction  Signals                              Transfer
// command   in         start, busy, func, vec_*, pos_*      start high, busy low
// result    out        done, right_*, upv_*, fwd_*, trans_*  done high for one cycle
//
// One transaction per cycle is taken; busy stays low.
// The pipeline has 9 setup stages, 31 root stages (one root bit each),
// 17 divider stages (one quotient bit each) and 6 product and rounding
// stages.
// rst_n clears every valid bit at once; results in flight are dropped.
// The receiver cannot stall, so the pipeline never holds.
module look_at_view_basis (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              func,
    input  lavb_pkg::pos_t    vec_x,
    input  lavb_pkg::pos_t    vec_y,
    input  lavb_pkg::pos_t    vec_z,
    input  lavb_pkg::pos_t    pos_x,
    input  lavb_pkg::pos_t    pos_y,
    input  lavb_pkg::pos_t    pos_z,
    output logic              done,
    output lavb_pkg::unit_t   right_x,
    output lavb_pkg::unit_t   right_y,
    output lavb_pkg::unit_t   right_z,
    output lavb_pkg::unit_t   upv_x,
    output lavb_pkg::unit_t   upv_y,
    output lavb_pkg::unit_t   upv_z,
    output lavb_pkg::unit_t   fwd_x,
    output lavb_pkg::unit_t   fwd_y,
    output lavb_pkg::unit_t   fwd_z,
    output lavb_pkg::pos_t    trans_u,
    output lavb_pkg::pos_t    trans_v,
    output lavb_pkg::pos_t    trans_w
);
    import lavb_pkg::*;

    logic  acc_valid;
    logic  prep_valid;
    rad_t  prep_rad [ROOTS];
    mags_t prep_mags;
    side_t prep_side;
    logic  sqrt_valid;
    root_t sqrt_root [ROOTS];
    mags_t sqrt_mags;
    side_t sqrt_side;
    norm_t div_mag [LANES];
    root_t div_den [LANES];
    logic  div_valid;
    quo_t  div_quo [LANES];
    side_t div_side;

    // Accept
    assign busy      = 1'b0;
    assign acc_valid = start && !busy;

    lavb_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (acc_valid),
        .func      (func),
        .vec_x     (vec_x),
        .vec_y     (vec_y),
        .vec_z     (vec_z),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .pos_z     (pos_z),
        .out_valid (prep_valid),
        .rad       (prep_rad),
        .mags      (prep_mags),
        .side      (prep_side)
    );

    lavb_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (prep_valid),
        .rad       (prep_rad),
        .mags_in   (prep_mags),
        .side_in   (prep_side),
        .out_valid (sqrt_valid),
        .root      (sqrt_root),
        .mags_out  (sqrt_mags),
        .side_out  (sqrt_side)
    );

    // Lane routing: w over full length, u over horizontal length
    assign div_mag[L_WX] = sqrt_mags.n_x;
    assign div_mag[L_WY] = sqrt_mags.n_y;
    assign div_mag[L_WZ] = sqrt_mags.n_z;
    assign div_mag[L_UX] = sqrt_mags.h_z;
    assign div_mag[L_UZ] = sqrt_mags.h_x;
    assign div_den[L_WX] = sqrt_root[ROOT_L];
    assign div_den[L_WY] = sqrt_root[ROOT_L];
    assign div_den[L_WZ] = sqrt_root[ROOT_L];
    assign div_den[L_UX] = sqrt_root[ROOT_H];
    assign div_den[L_UZ] = sqrt_root[ROOT_H];

    lavb_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sqrt_valid),
        .mag       (div_mag),
        .den       (div_den),
        .side_in   (sqrt_side),
        .out_valid (div_valid),
        .quo       (div_quo),
        .side_out  (div_side)
    );

    lavb_post u_post (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (div_valid),
        .quo      (div_quo),
        .side_in  (div_side),
        .done     (done),
        .right_x  (right_x),
        .right_z  (right_z),
        .upv_x    (upv_x),
        .upv_y    (upv_y),
        .upv_z    (upv_z),
        .fwd_x    (fwd_x),
        .fwd_y    (fwd_y),
        .fwd_z    (fwd_z),
        .trans_u  (trans_u),
        .trans_v  (trans_v),
        .trans_w  (trans_w)
    );

    // Up is the world y axis, so u has no y part
    assign right_y = '0;

endmodule

@@ hw/rtl/lavb_checker.sv @@
`include "assert_macros.svh"

module lavb_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               busy,
    input logic               done,
    input logic signed [17:0] right_x,
    input logic signed [17:0] right_y,
    input logic signed [17:0] right_z,
    input logic signed [17:0] upv_x,
    input logic signed [17:0] upv_y,
    input logic signed [17:0] upv_z,
    input logic signed [17:0] fwd_x,
    input logic signed [17:0] fwd_y,
    input logic signed [17:0] fwd_z,
    input logic signed [31:0] trans_u,
    input logic signed [31:0] trans_v,
    input logic signed [31:0] trans_w
);
    logic fwd_zero;
    logic right_zero;
    logic upv_zero;
    logic trans_zero;
    logic upv_in_range;
    logic fwd_in_range;

    assign fwd_zero   = (fwd_x == 18'sd0) && (fwd_y == 18'sd0) && (fwd_z == 18'sd0);
    assign right_zero = (right_x == 18'sd0) && (right_z == 18'sd0);
    assign upv_zero   = (upv_x == 18'sd0) && (upv_y == 18'sd0) && (upv_z == 18'sd0);
    assign trans_zero = (trans_u == 32'sd0) && (trans_v == 32'sd0) && (trans_w == 32'sd0);

    assign upv_in_range = (upv_x <= 18'sd65536) && (upv_x >= -18'sd65536)
                       && (upv_y <= 18'sd65536) && (upv_y >= -18'sd65536)
                       && (upv_z <= 18'sd65536) && (upv_z >= -18'sd65536);
    assign fwd_in_range = (fwd_x <= 18'sd65536) && (fwd_x >= -18'sd65536)
                       && (fwd_y <= 18'sd65536) && (fwd_y >= -18'sd65536)
                       && (fwd_z <= 18'sd65536) && (fwd_z >= -18'sd65536);

    // The pipeline never holds off a command
    `ASSERT_AT(a_never_busy, !busy, "busy raised")

    // A zero forward vector only comes from the degenerate case
    `ASSERT_IMP(a_degen_all_zero, done && fwd_zero, right_zero && (right_y == 18'sd0) && upv_zero && trans_zero, "degenerate result not all zero")

    // A valid basis always has a horizontal right vector
    `ASSERT_IMP(a_right_nonzero, done && !fwd_zero, !right_zero, "right vector zero on valid basis")

    // Up and forward unit components stay inside one
    `ASSERT_IMP(a_upv_range, done, upv_in_range, "up vector out of range")

    `ASSERT_IMP(a_fwd_range, done, fwd_in_range, "forward vector out of range")

endmodule

bind look_at_view_basis lavb_checker u_lavb_checker (.*);

@@ tb/tb_look_at_view_basis.sv @@
`timescale 1ns / 1ps

module tb_look_at_view_basis;
    import lavb_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 70;

    typedef struct {
        unit_t right_x, right_y, right_z;
        unit_t upv_x, upv_y, upv_z;
        unit_t fwd_x, fwd_y, fwd_z;
        pos_t  trans_u, trans_v, trans_w;
    } basis_t;

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  start = 1'b0;
    logic  func = 1'b0;
    pos_t  vec_x = '0, vec_y = '0, vec_z = '0;
    pos_t  pos_x = '0, pos_y = '0, pos_z = '0;
    logic  busy, done;
    unit_t right_x, right_y, right_z, upv_x, upv_y, upv_z, fwd_x, fwd_y, fwd_z;
    pos_t  trans_u, trans_v, trans_w;

    basis_t pending_basis[$];
    int     mismatches = 0;
    int     n_sent = 0;
    int     n_checked = 0;
    int     n_degen = 0;
    int     idle_cycles = 0;

    always #1 clk = ~clk;

    look_at_view_basis u_dut (.*);

    // Integer square root, floor
    function automatic longint unsigned isqrt(longint unsigned n);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n)
            b >>= 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    function automatic longint unit_div(bit neg, longint unsigned mag, longint unsigned den);
        longint unsigned q;
        q = ((mag << UNIT_FRAC) + den / 2) / den;
        return neg ? -longint'(q) : longint'(q);
    endfunction

    // Divide by 2^16, round half away from zero
    function automatic longint rnd16(longint x);
        if (x >= 0)
            return (x + 32768) >>> 16;
        return -((-x + 32768) >>> 16);
    endfunction

    function automatic longint clamp_unit(longint x);
        if (x > 65536)
            return 65536;
        if (x < -65536)
            return -65536;
        return x;
    endfunction

    function automatic pos_t sat_trans(longint a, longint b, longint c,
                                       longint px, longint py, longint pz);
        longint r;
        r = -rnd16(a * px + b * py + c * pz);
        if (r > 64'sd2147483647)
            r = 64'sd2147483647;
        if (r < -64'sd2147483648)
            r = -64'sd2147483648;
        return pos_t'(r);
    endfunction

    // Expected look-at basis for one command
    function automatic basis_t predict_basis(logic f, pos_t vx, pos_t vy, pos_t vz,
                                             pos_t px, pos_t py, pos_t pz);
        basis_t          e;
        longint          d[3];
        longint unsigned m[3];
        longint unsigned mx, hx, hz, len_l, len_h;
        longint          wx, wy, wz, ux, uz, vx_o, vy_o, vz_o;
        e = '{default: '0};
        d[0] = longint'(vx);
        d[1] = longint'(vy);
        d[2] = longint'(vz);
        if (f) begin
            d[0] -= longint'(px);
            d[1] -= longint'(py);
            d[2] -= longint'(pz);
        end
        for (int i = 0; i < 3; i++)
            m[i] = d[i] < 0 ? longint'(-d[i]) : d[i];
        mx = m[0];
        if (m[1] > mx) mx = m[1];
        if (m[2] > mx) mx = m[2];
        if (mx == 0)
            return e;
        while (mx >= (64'd1 << 30)) begin
            mx >>= 1;
            for (int i = 0; i < 3; i++) m[i] >>= 1;
        end
        while (mx < (64'd1 << 29)) begin
            mx <<= 1;
            for (int i = 0; i < 3; i++) m[i] <<= 1;
        end
        // parallel to up after pre-scale
        if (m[0] == 0 && m[2] == 0)
            return e;
        len_l = isqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
        wx = unit_div(d[0] < 0, m[0], len_l);
        wy = unit_div(d[1] < 0, m[1], len_l);
        wz = unit_div(d[2] < 0, m[2], len_l);
        hx = m[0];
        hz = m[2];
        while ((hx > hz ? hx : hz) < (64'd1 << 29)) begin
            hx <<= 1;
            hz <<= 1;
        end
        len_h = isqrt(hx * hx + hz * hz);
        ux = unit_div(!(d[2] < 0) && hz != 0, hz, len_h);
        uz = unit_div(d[0] < 0, hx, len_h);
        vx_o = clamp_unit(rnd16(wy * uz));
        vy_o = clamp_unit(rnd16(wz * ux - wx * uz));
        vz_o = clamp_unit(rnd16(-(wy * ux)));
        e.right_x = unit_t'(ux);
        e.right_z = unit_t'(uz);
        e.upv_x = unit_t'(vx_o);
        e.upv_y = unit_t'(vy_o);
        e.upv_z = unit_t'(vz_o);
        e.fwd_x = unit_t'(wx);
        e.fwd_y = unit_t'(wy);
        e.fwd_z = unit_t'(wz);
        e.trans_u = sat_trans(ux, 0, uz, px, py, pz);
        e.trans_v = sat_trans(vx_o, vy_o, vz_o, px, py, pz);
        e.trans_w = sat_trans(wx, wy, wz, px, py, pz);
        return e;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        mismatches++;
        $display("MISMATCH result %0d %s: got %0d expected %0d", n_checked, field, got, want);
    endtask

    // Record accepted commands, check each result against the oldest prediction
    always @(posedge clk)
    begin
        basis_t e;
        if (rst_n) begin
            if ((start && !busy) || done)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (start && !busy) begin
                e = predict_basis(func, vec_x, vec_y, vec_z, pos_x, pos_y, pos_z);
                if (e.fwd_x == 0 && e.fwd_y == 0 && e.fwd_z == 0)
                    n_degen++;
                pending_basis.push_back(e);
            end
            if (done) begin
                if (pending_basis.size() == 0) begin
                    report_mismatch("unexpected done", 1, 0);
                end
                else begin
                    e = pending_basis.pop_front();
                    if (right_x !== e.right_x) report_mismatch("right_x", right_x, e.right_x);
                    if (right_y !== e.right_y) report_mismatch("right_y", right_y, e.right_y);
                    if (right_z !== e.right_z) report_mismatch("right_z", right_z, e.right_z);
                    if (upv_x !== e.upv_x) report_mismatch("upv_x", upv_x, e.upv_x);
                    if (upv_y !== e.upv_y) report_mismatch("upv_y", upv_y, e.upv_y);
                    if (upv_z !== e.upv_z) report_mismatch("upv_z", upv_z, e.upv_z);
                    if (fwd_x !== e.fwd_x) report_mismatch("fwd_x", fwd_x, e.fwd_x);
                    if (fwd_y !== e.fwd_y) report_mismatch("fwd_y", fwd_y, e.fwd_y);
                    if (fwd_z !== e.fwd_z) report_mismatch("fwd_z", fwd_z, e.fwd_z);
                    if (trans_u !== e.trans_u) report_mismatch("trans_u", trans_u, e.trans_u);
                    if (trans_v !== e.trans_v) report_mismatch("trans_v", trans_v, e.trans_v);
                    if (trans_w !== e.trans_w) report_mismatch("trans_w", trans_w, e.trans_w);
                    n_checked++;
                end
            end
        end
    end

    // Watchdog on cycles with no transaction on either side
    always @(posedge clk)
    begin
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d results outstanding", pending_basis.size());
            $display("tb_look_at_view_basis: errors");
            $finish;
        end
    end

    // Drive one command and hold it until accepted
    task automatic send_cmd(logic f, pos_t vx, pos_t vy, pos_t vz,
                            pos_t px, pos_t py, pos_t pz);
        start <= 1'b1;
        func <= f;
        vec_x <= vx;
        vec_y <= vy;
        vec_z <= vz;
        pos_x <= px;
        pos_y <= py;
        pos_z <= pz;
        do
            @(posedge clk);
        while (busy);
        n_sent++;
    endtask

    task automatic pause(int cycles);
        if (cycles > 0) begin
            start <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // Random value with random magnitude so small and large scales both appear
    function automatic pos_t rand_val();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return '0;
        if (sel < 5)
            return pos_t'($urandom);
        return pos_t'($signed($urandom) >>> $urandom_range(1, 31));
    endfunction

    task automatic test_directed();
        pos_t mx, mn;
        mx = 32'sh7fffffff;
        mn = 32'sh80000000;
        // zero direction, both forms
        send_cmd(1'b0, 0, 0, 0, 0, 0, 0);
        send_cmd(1'b1, 100, -5, 7, 100, -5, 7);
        // straight up and straight down
        send_cmd(1'b0, 0, 32'sh10000, 0, 5, 6, 7);
        send_cmd(1'b0, 0, mn, 0, mx, mn, mx);
        // x and z shifted out by the pre-scale
        send_cmd(1'b0, 1, mx, -1, 0, 0, 0);
        send_cmd(1'b0, 3, mn, 2, 0, 0, 0);
        // barely survives the pre-scale
        send_cmd(1'b0, 4, mx, 0, 1, 1, 1);
        // axis directions
        send_cmd(1'b0, 32'sh10000, 0, 0, 0, 0, 0);
        send_cmd(1'b0, 0, 0, -32'sh10000, 32'sh10000, 32'sh20000, 32'sh30000);
        send_cmd(1'b0, 1, 0, 0, 0, 0, 0);
        send_cmd(1'b0, 0, 0, -1, 0, 0, 0);
        // field extremes
        send_cmd(1'b0, mx, mx, mx, mx, mx, mx);
        send_cmd(1'b0, mn, mn, mn, mn, mn, mn);
        send_cmd(1'b0, mn, mx, mn, mx, mn, mx);
        // target form with 33-bit differences
        send_cmd(1'b1, mx, mn, mx, mn, mx, mn);
        send_cmd(1'b1, mn, mx, mn, mx, mn, mx);
        send_cmd(1'b1, mn, 0, mx, mx, 0, mn);
        // translation saturation both ways
        send_cmd(1'b0, mx, 0, mx, mn, mn, mn);
        send_cmd(1'b0, mn, 0, mn, mn, mn, mn);
        send_cmd(1'b0, 1, 1, 1, mx, mx, mx);
        send_cmd(1'b1, 0, 0, 0, -1, 0, 0);
        pause(1);
    endtask

    task automatic test_random(int count, int target_pct);
        int left;
        int burst;
        pos_t px, py, pz;
        left = count;
        while (left > 0) begin
            burst = $urandom_range(1, 30);
            while (burst > 0 && left > 0) begin
                px = rand_val();
                py = rand_val();
                pz = rand_val();
                case ($urandom_range(0, 19))
                    // parallel to up, sometimes only after shifting
                    0: send_cmd(1'b0, $urandom_range(0, 3), rand_val(), $urandom_range(0, 3),
                                px, py, pz);
                    1: send_cmd(1'b1, px, rand_val(), pz, px, py, pz);
                    default: send_cmd($urandom_range(0, 99) < target_pct, rand_val(),
                                      rand_val(), rand_val(), px, py, pz);
                endcase
                burst--;
                left--;
            end
            // runs of back-to-back bursts with no gap at all
            pause($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12));
        end
        pause(1);
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(500, 0);
        test_random(500, 100);
        test_random(500, 50);
        while (pending_basis.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("covered %0d commands, %0d results checked, %0d degenerate",
                 n_sent, n_checked, n_degen);
        $display("direction and target forms, field extremes, saturated translation");
        if (mismatches == 0)
            $display("tb_look_at_view_basis: clean");
        else
            $display("tb_look_at_view_basis: errors");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/lavb_pkg.sv
hw/rtl/lavb_prep.sv
hw/rtl/lavb_sqrt.sv
hw/rtl/lavb_div.sv
hw/rtl/lavb_post.sv
hw/rtl/look_at_view_basis.sv
hw/rtl/lavb_checker.sv
tb/tb_look_at_view_basis.sv
